>>> hw/rtl/bitfield_pixel_to_rgba8_assert.svh
// assertion macros for the pixel unpacker
`ifndef BITFIELD_PIXEL_TO_RGBA8_ASSERT_SVH
`define BITFIELD_PIXEL_TO_RGBA8_ASSERT_SVH

// condition holds in the same cycle
`define BFP_ASSERT_NOW(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("bitfield_pixel_to_rgba8 check failed");

// condition holds after the antecedent (latency check)
`define BFP_ASSERT_LAT2(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> ##2 (b)) \
		else $error("bitfield_pixel_to_rgba8 latency check failed");

`endif

>>> hw/rtl/bfp2rgba_pkg.sv
`default_nettype none
package bfp2rgba_pkg;

	localparam int unsigned RegIdxW = 3;

	localparam logic [RegIdxW-1:0] REG_RED_MASK   = 3'd0;
	localparam logic [RegIdxW-1:0] REG_GREEN_MASK = 3'd1;
	localparam logic [RegIdxW-1:0] REG_BLUE_MASK  = 3'd2;
	localparam logic [RegIdxW-1:0] REG_ALPHA_MASK = 3'd3;
	localparam logic [RegIdxW-1:0] REG_BPP        = 3'd4;

	localparam logic [2:0] BPP_RESET = 3'd4;

	typedef struct packed {
		logic [31:0] emask;
		logic [4:0]  shift;
		logic [3:0]  size;
	} chan_prm_t;

	typedef struct packed {
		chan_prm_t red;
		chan_prm_t green;
		chan_prm_t blue;
		chan_prm_t alpha;
		logic      overlap;
	} cfg_prm_t;

	// nearest of c*255/(2^n-1), sizes 1 to 7 back to back
	localparam logic [7:0] WIDEN_TAB [254] = '{
		8'd0, 8'd255,
		8'd0, 8'd85, 8'd170, 8'd255,
		8'd0, 8'd36, 8'd73, 8'd109, 8'd146, 8'd182, 8'd219, 8'd255,
		8'd0, 8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102, 8'd119,
		8'd136, 8'd153, 8'd170, 8'd187, 8'd204, 8'd221, 8'd238, 8'd255,
		8'd0, 8'd8, 8'd16, 8'd25, 8'd33, 8'd41, 8'd49, 8'd58,
		8'd66, 8'd74, 8'd82, 8'd90, 8'd99, 8'd107, 8'd115, 8'd123,
		8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
		8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255,
		8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28,
		8'd32, 8'd36, 8'd40, 8'd45, 8'd49, 8'd53, 8'd57, 8'd61,
		8'd65, 8'd69, 8'd73, 8'd77, 8'd81, 8'd85, 8'd89, 8'd93,
		8'd97, 8'd101, 8'd105, 8'd109, 8'd113, 8'd117, 8'd121, 8'd125,
		8'd130, 8'd134, 8'd138, 8'd142, 8'd146, 8'd150, 8'd154, 8'd158,
		8'd162, 8'd166, 8'd170, 8'd174, 8'd178, 8'd182, 8'd186, 8'd190,
		8'd194, 8'd198, 8'd202, 8'd206, 8'd210, 8'd215, 8'd219, 8'd223,
		8'd227, 8'd231, 8'd235, 8'd239, 8'd243, 8'd247, 8'd251, 8'd255,
		8'd0, 8'd2, 8'd4, 8'd6, 8'd8, 8'd10, 8'd12, 8'd14,
		8'd16, 8'd18, 8'd20, 8'd22, 8'd24, 8'd26, 8'd28, 8'd30,
		8'd32, 8'd34, 8'd36, 8'd38, 8'd40, 8'd42, 8'd44, 8'd46,
		8'd48, 8'd50, 8'd52, 8'd54, 8'd56, 8'd58, 8'd60, 8'd62,
		8'd64, 8'd66, 8'd68, 8'd70, 8'd72, 8'd74, 8'd76, 8'd78,
		8'd80, 8'd82, 8'd84, 8'd86, 8'd88, 8'd90, 8'd92, 8'd94,
		8'd96, 8'd98, 8'd100, 8'd102, 8'd104, 8'd106, 8'd108, 8'd110,
		8'd112, 8'd114, 8'd116, 8'd118, 8'd120, 8'd122, 8'd124, 8'd126,
		8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd139, 8'd141, 8'd143,
		8'd145, 8'd147, 8'd149, 8'd151, 8'd153, 8'd155, 8'd157, 8'd159,
		8'd161, 8'd163, 8'd165, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
		8'd177, 8'd179, 8'd181, 8'd183, 8'd185, 8'd187, 8'd189, 8'd191,
		8'd193, 8'd195, 8'd197, 8'd199, 8'd201, 8'd203, 8'd205, 8'd207,
		8'd209, 8'd211, 8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd223,
		8'd225, 8'd227, 8'd229, 8'd231, 8'd233, 8'd235, 8'd237, 8'd239,
		8'd241, 8'd243, 8'd245, 8'd247, 8'd249, 8'd251, 8'd253, 8'd255
	};

endpackage
`default_nettype wire

>>> hw/rtl/bitfield_pixel_to_rgba8.sv
// Bitfield pixel unpacker. One pixel word is taken per clock (busy never
// rises) and its red, green, blue and alpha bytes come out through the
// input register and the result register around the extract and widen
// logic, flagged by a one-cycle done pulse; the receiver has no way to
// stall, so it must take every result in the cycle that done is high.
// Register writes reach the decode setup through the mask registers and
// the derived setup register; masks that share a bit within the enabled
// pixel bytes raise masks_overlap and zero the channels.
`default_nettype none
module bitfield_pixel_to_rgba8 (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [bfp2rgba_pkg::RegIdxW-1:0] wr_index,
	input  wire logic [31:0]                       wr_data,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [31:0]                       pixel_word,
	output logic                                   done,
	output logic [7:0]                             red_out,
	output logic [7:0]                             green_out,
	output logic [7:0]                             blue_out,
	output logic [7:0]                             alpha_out,
	output logic                                   masks_overlap
);
	import bfp2rgba_pkg::*;

	`include "bitfield_pixel_to_rgba8_assert.svh"

	cfg_prm_t    prm;
	logic [31:0] pixel_s1;
	logic        valid_s1;
	logic [7:0]  red_v, green_v, blue_v, alpha_v;

	assign busy = 1'b0;

	bfp2rgba_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.prm      (prm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pixel_s1 <= pixel_word;
		end
	end

	bfp2rgba_chan u_red   (.pixel(pixel_s1), .prm(prm.red),   .value(red_v));
	bfp2rgba_chan u_green (.pixel(pixel_s1), .prm(prm.green), .value(green_v));
	bfp2rgba_chan u_blue  (.pixel(pixel_s1), .prm(prm.blue),  .value(blue_v));
	bfp2rgba_chan u_alpha (.pixel(pixel_s1), .prm(prm.alpha), .value(alpha_v));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			red_out       <= prm.overlap ? 8'd0 : red_v;
			green_out     <= prm.overlap ? 8'd0 : green_v;
			blue_out      <= prm.overlap ? 8'd0 : blue_v;
			alpha_out     <= prm.overlap ? 8'd0 : alpha_v;
			masks_overlap <= prm.overlap;
		end
	end

	`BFP_ASSERT_LAT2(a_start_to_done, start && !busy, done)
	`BFP_ASSERT_NOW(a_done_has_start, done, $past(start, 2))
	`BFP_ASSERT_NOW(a_overlap_zero, done && masks_overlap,
		red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && alpha_out == 8'd0)

endmodule
`default_nettype wire

>>> hw/rtl/bfp2rgba_cfg.sv
`default_nettype none
module bfp2rgba_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [bfp2rgba_pkg::RegIdxW-1:0] wr_index,
	input  wire logic [31:0]                       wr_data,
	output bfp2rgba_pkg::cfg_prm_t                 prm
);
	import bfp2rgba_pkg::*;

	logic [31:0] red_mask_q;
	logic [31:0] green_mask_q;
	logic [31:0] blue_mask_q;
	logic [31:0] alpha_mask_q;
	logic [2:0]  bpp_q;
	logic [31:0] trim;
	logic [31:0] r_m, g_m, b_m, a_m;
	cfg_prm_t    prm_d;
	cfg_prm_t    prm_q;

	function automatic chan_prm_t derive(input logic [31:0] m);
		logic [4:0] lo;
		logic [4:0] hi;
		logic [5:0] span;
		chan_prm_t  p;
		lo = 5'd31;
		hi = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (m[i]) lo = 5'(i);
		end
		for (int i = 0; i < 32; i++) begin
			if (m[i]) hi = 5'(i);
		end
		span = {1'b0, hi} - {1'b0, lo} + 6'd1;
		if (m == 32'd0) begin
			p.shift = 5'd0;
			p.size  = 4'd0;
		end else if (span > 6'd8) begin
			p.shift = hi - 5'd7;
			p.size  = 4'd8;
		end else begin
			p.shift = lo;
			p.size  = span[3:0];
		end
		p.emask = m & (32'hFF << p.shift);
		return p;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_mask_q   <= '0;
			green_mask_q <= '0;
			blue_mask_q  <= '0;
			alpha_mask_q <= '0;
			bpp_q        <= BPP_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_RED_MASK:   red_mask_q   <= wr_data;
				REG_GREEN_MASK: green_mask_q <= wr_data;
				REG_BLUE_MASK:  blue_mask_q  <= wr_data;
				REG_ALPHA_MASK: alpha_mask_q <= wr_data;
				REG_BPP:        bpp_q        <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (bpp_q)
			3'd0:    trim = 32'h0000_0000;
			3'd1:    trim = 32'h0000_00FF;
			3'd2:    trim = 32'h0000_FFFF;
			3'd3:    trim = 32'h00FF_FFFF;
			default: trim = 32'hFFFF_FFFF;
		endcase
		r_m = red_mask_q & trim;
		g_m = green_mask_q & trim;
		b_m = blue_mask_q & trim;
		a_m = alpha_mask_q & trim;
		prm_d.red     = derive(r_m);
		prm_d.green   = derive(g_m);
		prm_d.blue    = derive(b_m);
		prm_d.alpha   = derive(a_m);
		prm_d.overlap = ((r_m & g_m) | (r_m & b_m) | (r_m & a_m) |
			(g_m & b_m) | (g_m & a_m) | (b_m & a_m)) != 32'd0;
	end

	// derived channel setup, registered after the mask registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prm_q <= '0;
		end else begin
			prm_q <= prm_d;
		end
	end

	assign prm = prm_q;

endmodule
`default_nettype wire

>>> hw/rtl/bfp2rgba_chan.sv
`default_nettype none
module bfp2rgba_chan (
	input  wire logic [31:0]            pixel,
	input  wire bfp2rgba_pkg::chan_prm_t prm,
	output logic [7:0]                  value
);
	import bfp2rgba_pkg::*;

	logic [7:0] raw;
	logic [7:0] idx;

	always_comb begin
		raw = 8'((pixel & prm.emask) >> prm.shift);
		idx = (8'd1 << prm.size[2:0]) - 8'd2 + raw;
		case (prm.size)
			4'd0:    value = 8'd0;
			4'd8:    value = raw;
			default: value = WIDEN_TAB[idx];
		endcase
	end

endmodule
`default_nettype wire

>>> tb/sv/bitfield_pixel_to_rgba8_tb.sv
`default_nettype none
module bitfield_pixel_to_rgba8_tb;
	import bfp2rgba_pkg::*;

	localparam int QUIET_LIMIT = 300;
	localparam int PHASES = 16;
	localparam int PIXELS_PER_PHASE = 125;
	localparam logic [RegIdxW-1:0] REG_SPARE_LO = REG_BPP + 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       ovl;
	} rgba8_t;

	typedef struct packed {
		logic [31:0] rmask;
		logic [31:0] gmask;
		logic [31:0] bmask;
		logic [31:0] amask;
		logic [2:0]  bytes;
		logic [31:0] pixel;
		logic        typed;
		rgba8_t      want;
	} pix_case_t;

	localparam logic [31:0] AR_R = 32'h00FF_0000, AR_G = 32'h0000_FF00;
	localparam logic [31:0] AR_B = 32'h0000_00FF, AR_A = 32'hFF00_0000;
	localparam logic [31:0] ONES = 32'hFFFF_FFFF;

	pix_case_t dir_cases [21] = '{
		'{32'h0, 32'h0, 32'h0, 32'h0, 3'd4, ONES, 1'b1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{AR_R, AR_G, AR_B, AR_A, 3'd4, 32'h1234_5678, 1'b1,
			{8'h34, 8'h56, 8'h78, 8'h12, 1'b0}},
		'{AR_R, AR_G, AR_B, AR_A, 3'd4, ONES, 1'b1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
		'{AR_R, AR_G, AR_B, AR_A, 3'd4, 32'h0, 1'b1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{AR_R, AR_G, AR_B, AR_A, 3'd5, 32'h1234_5678, 1'b1,
			{8'h34, 8'h56, 8'h78, 8'h12, 1'b0}},
		'{AR_R, AR_G, AR_B, AR_A, 3'd7, 32'h8765_4321, 1'b1,
			{8'h65, 8'h43, 8'h21, 8'h87, 1'b0}},
		'{AR_R, AR_G, AR_B, AR_A, 3'd0, ONES, 1'b1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{ONES, ONES, ONES, ONES, 3'd0, ONES, 1'b1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{ONES, ONES, ONES, ONES, 3'd4, ONES, 1'b1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
		'{32'hFF, 32'h0F, 32'h0, 32'h0, 3'd1, ONES, 1'b1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
		'{AR_A, AR_A, 32'hFF, 32'h0, 3'd3, ONES, 1'b1, {8'h00, 8'h00, 8'hFF, 8'h00, 1'b0}},
		'{32'hF800, 32'h07E0, 32'h001F, 32'h0, 3'd2, 32'hFFFF, 1'b1,
			{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0}},
		'{32'hF800, 32'h07E0, 32'h001F, 32'h0, 3'd2, 32'hFFFF_0000, 1'b1,
			{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{32'hF800, 32'h07E0, 32'h001F, 32'h0, 3'd2, 32'h8410, 1'b0, '0},
		'{32'hE0, 32'h1C, 32'h03, 32'h100, 3'd1, ONES, 1'b1,
			{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0}},
		'{32'hE0, 32'h1C, 32'h03, 32'h100, 3'd1, 32'h25, 1'b0, '0},
		'{32'h101, 32'h00F0_0000, 32'h8000_0000, 32'h0001_FC00, 3'd4, 32'h8055_A5FF,
			1'b0, '0},
		'{ONES, 32'h0, 32'h0, 32'h0, 3'd4, 32'hA500_0000, 1'b0, '0},
		'{ONES, 32'h0, 32'h0, 32'h0, 3'd2, 32'h0000_C3FF, 1'b0, '0},
		'{32'h7F, 32'h1F80, 32'hE000, 32'h0001_0000, 3'd3, 32'h0001_5555, 1'b0, '0},
		'{32'h7F, 32'h1F80, 32'hE000, 32'h0001_0000, 3'd3, 32'h00FF_FFFF, 1'b1,
			{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}}
	};

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic [RegIdxW-1:0]  wr_index;
	logic [31:0]         wr_data;
	logic                start;
	logic                busy;
	logic [31:0]         pixel_word;
	logic                done;
	logic [7:0]          red_out;
	logic [7:0]          green_out;
	logic [7:0]          blue_out;
	logic [7:0]          alpha_out;
	logic                masks_overlap;

	logic [31:0] sh_mask [4];
	logic [2:0]  pix_bytes;
	rgba8_t      rgba_expq [$];
	logic        exp_typed;
	rgba8_t      exp_word;
	int          bad_count;
	int          quiet_cycles;

	bitfield_pixel_to_rgba8 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.start         (start),
		.busy          (busy),
		.pixel_word    (pixel_word),
		.done          (done),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.alpha_out     (alpha_out),
		.masks_overlap (masks_overlap)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] chan_byte(input logic [31:0] pix, input logic [31:0] msk);
		int lo;
		int hi;
		int span;
		int val;
		int top_code;
		logic [31:0] field;
		if (msk == 32'd0)
			return 8'd0;
		lo = 0;
		hi = 0;
		for (int i = 31; i >= 0; i--)
			if (msk[i])
				lo = i;
		for (int i = 0; i < 32; i++)
			if (msk[i])
				hi = i;
		span = hi - lo + 1;
		// wide fields keep only their top byte
		if (span > 8) begin
			lo = lo + span - 8;
			span = 8;
		end
		field = ((pix & msk) >> lo) & ((32'd1 << span) - 32'd1);
		if (span == 8)
			return field[7:0];
		val = int'(field);
		top_code = (1 << span) - 1;
		// nearest of val * 255 / top_code
		return 8'((2 * val * 255 + top_code) / (2 * top_code));
	endfunction

	function automatic rgba8_t unpack_rgba(input logic [31:0] pix);
		logic [31:0] keep;
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
		logic [31:0] a;
		rgba8_t res;
		keep = (pix_bytes >= 3'd4) ? ONES : ((32'd1 << (8 * pix_bytes)) - 32'd1);
		r = sh_mask[0] & keep;
		g = sh_mask[1] & keep;
		b = sh_mask[2] & keep;
		a = sh_mask[3] & keep;
		res = '0;
		res.ovl = |((r & g) | (r & b) | (r & a) | (g & b) | (g & a) | (b & a));
		if (!res.ovl) begin
			res.red = chan_byte(pix, r);
			res.green = chan_byte(pix, g);
			res.blue = chan_byte(pix, b);
			res.alpha = chan_byte(pix, a);
		end
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] %s", $realtime, msg);
		bad_count++;
	endtask

	always @(posedge clk) begin : rgba_monitor
		rgba8_t want;
		if (arst_n) begin
			if (done) begin
				if (rgba_expq.size() == 0) begin
					flag_mismatch("unexpected result transfer");
				end else begin
					want = rgba_expq.pop_front();
					if (red_out !== want.red)
						flag_mismatch($sformatf("red_out %h, want %h", red_out, want.red));
					if (green_out !== want.green)
						flag_mismatch($sformatf("green_out %h, want %h", green_out,
							want.green));
					if (blue_out !== want.blue)
						flag_mismatch($sformatf("blue_out %h, want %h", blue_out, want.blue));
					if (alpha_out !== want.alpha)
						flag_mismatch($sformatf("alpha_out %h, want %h", alpha_out,
							want.alpha));
					if (masks_overlap !== want.ovl)
						flag_mismatch($sformatf("masks_overlap %b, want %b", masks_overlap,
							want.ovl));
				end
			end
			if (start && !busy)
				rgba_expq.push_back(exp_typed ? exp_word : unpack_rgba(pixel_word));
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("bitfield_pixel_to_rgba8: mismatch");
			$finish;
		end
	end

	task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		if (idx <= REG_ALPHA_MASK)
			sh_mask[idx - REG_RED_MASK] = data;
		else if (idx == REG_BPP)
			pix_bytes = data[2:0];
	endtask

	task automatic load_layout(input logic [31:0] m_r, input logic [31:0] m_g,
		input logic [31:0] m_b, input logic [31:0] m_a, input logic [31:0] bytes_word);
		@(negedge clk);
		start = 1'b0;
		while (rgba_expq.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_RED_MASK, m_r);
		write_reg(REG_GREEN_MASK, m_g);
		write_reg(REG_BLUE_MASK, m_b);
		write_reg(REG_ALPHA_MASK, m_a);
		// unmapped indexes must be ignored
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE_LO + RegIdxW'($urandom_range(0, 2)), $urandom);
		write_reg(REG_BPP, bytes_word);
		@(negedge clk);
		wr_en = 1'b0;
		wr_data = '0;
		repeat (3) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [31:0] word, input logic typed, input rgba8_t want);
		@(negedge clk);
		start = 1'b1;
		pixel_word = word;
		exp_typed = typed;
		exp_word = want;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
			pixel_word = $urandom;
		end
	endtask

	task automatic random_layout();
		logic [31:0] lay [4];
		logic [31:0] bw;
		int kind;
		int pos;
		int len;
		int first;
		int own;
		kind = $urandom_range(0, 9);
		foreach (lay[c])
			lay[c] = '0;
		if (kind <= 5) begin
			// disjoint contiguous fields, sizes 0 to 10
			pos = $urandom_range(0, 3);
			first = $urandom_range(0, 3);
			for (int c = 0; c < 4; c++) begin
				len = $urandom_range(0, 10);
				lay[(first + c) % 4] = 32'(((64'd1 << len) - 64'd1) << pos);
				pos += len + $urandom_range(0, 2);
			end
		end else if (kind <= 7) begin
			// disjoint but scattered bits
			for (int i = 0; i < 32; i++) begin
				own = $urandom_range(0, 5);
				if (own < 4)
					lay[own][i] = 1'b1;
			end
		end else begin
			foreach (lay[c])
				lay[c] = $urandom & $urandom;
		end
		bw = $urandom_range(0, 1) ? $urandom : 32'd0;
		bw[2:0] = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4))
			: 3'($urandom_range(0, 7));
		load_layout(lay[0], lay[1], lay[2], lay[3], bw);
	endtask

	initial begin
		int idle_pct;
		int sel;
		logic [31:0] word;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		start = 1'b0;
		pixel_word = '0;
		exp_typed = 1'b0;
		exp_word = '0;
		bad_count = 0;
		quiet_cycles = 0;
		foreach (sh_mask[c])
			sh_mask[c] = '0;
		pix_bytes = BPP_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_cases[k]) begin
			if ({dir_cases[k].rmask, dir_cases[k].gmask, dir_cases[k].bmask,
				dir_cases[k].amask, dir_cases[k].bytes} !=
				{sh_mask[0], sh_mask[1], sh_mask[2], sh_mask[3], pix_bytes})
				load_layout(dir_cases[k].rmask, dir_cases[k].gmask, dir_cases[k].bmask,
					dir_cases[k].amask, {29'd0, dir_cases[k].bytes});
			send_pixel(dir_cases[k].pixel, dir_cases[k].typed, dir_cases[k].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				1: idle_pct = 48;
				3: idle_pct = 22;
				default: idle_pct = 0;
			endcase
			random_layout();
			for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
				while ($urandom_range(0, 99) < idle_pct)
					idle_cycles(1);
				sel = $urandom_range(0, 15);
				if (sel == 0)
					word = '0;
				else if (sel == 1)
					word = ONES;
				else
					word = $urandom;
				send_pixel(word, 1'b0, '0);
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (rgba_expq.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (bad_count == 0)
			$display("bitfield_pixel_to_rgba8: match");
		else
			$display("bitfield_pixel_to_rgba8: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

>>> bitfield_pixel_to_rgba8.f
+incdir+hw/rtl
hw/rtl/bfp2rgba_pkg.sv
hw/rtl/bfp2rgba_cfg.sv
hw/rtl/bfp2rgba_chan.sv
hw/rtl/bitfield_pixel_to_rgba8.sv
tb/sv/bitfield_pixel_to_rgba8_tb.sv
